[sv/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int TIME_W = 16;
  localparam int DONE_W = 5;
  localparam int PC_W   = 5;
  localparam int PC_RESET = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [DONE_W-1:0] DONE_MAX = '1;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TICK = 1'b1
  } func_t;

  typedef enum logic {
    REG_PROCESS_COUNT = 1'b0,
    REG_UNMAPPED      = 1'b1
  } reg_idx_t;

  typedef struct packed {
    func_t             func;
    logic [3:0]        slot;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] prio;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remain;
    logic [TIME_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [3:0]        running_slot;
    logic              idle;
    logic              finished;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] waiting_time;
    logic              all_done;
  } res_t;

endpackage

[sv/pps_ram.sv]
// ----------------------------------------------------------------------------
// pps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/pps_core.sv]
// ----------------------------------------------------------------------------
// pps_core
// Scheduling engine: scans the process table in RAM one slot per cycle,
// keeps the best ready slot, then writes back its remaining work.
// ----------------------------------------------------------------------------
module pps_core
  import pps_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [PC_W-1:0] process_count_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  item_t           in_item_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output res_t            res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_HOLD
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] chk_r, chk_nxt;
  logic [SLOT_W-1:0] best_idx_r, best_idx_nxt;
  logic              found_r, found_nxt;
  entry_t            best_r, best_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [DONE_W-1:0] done_r, done_nxt;
  res_t              res_r, res_nxt;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  entry_t            ent;
  logic [CNT_W-1:0]  n_act;
  logic [SLOT_W-1:0] last_idx;
  logic              cand;
  logic              better;
  logic [TIME_W-1:0] time_inc;
  logic [TIME_W-1:0] tat;
  logic [TIME_W-1:0] wt;

  pps_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ent      = entry_t'(ram_rdata);
  assign n_act    = (32'(process_count_i) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(process_count_i);
  assign last_idx = SLOT_W'(n_act - CNT_W'(1));
  assign cand     = (ent.arrival <= time_r) && (ent.remain != '0);
  assign better   = cand && (!found_r || (ent.prio < best_r.prio));
  assign time_inc = (time_r != TIME_MAX) ? time_r + TIME_W'(1) : time_r;
  assign tat      = (time_inc >= best_r.arrival) ? time_inc - best_r.arrival : '0;
  assign wt       = (tat >= best_r.burst) ? tat - best_r.burst : '0;

  assign in_ready_o  = (state_r == ST_IDLE);
  assign res_valid_o = (state_r == ST_HOLD);
  assign res_o       = res_r;

  always_comb begin
    state_nxt    = state_r;
    chk_nxt      = chk_r;
    best_idx_nxt = best_idx_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    time_nxt     = time_r;
    done_nxt     = done_r;
    res_nxt      = res_r;
    ram_we       = 1'b0;
    ram_waddr    = best_idx_r;
    ram_wdata    = best_r;
    ram_raddr    = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.func == FUNC_LOAD) begin
            if (32'(in_item_i.slot) < SLOTS) begin
              ram_we            = 1'b1;
              ram_waddr         = SLOT_W'(in_item_i.slot);
              ram_wdata.arrival = in_item_i.arrival;
              ram_wdata.burst   = in_item_i.burst;
              ram_wdata.remain  = in_item_i.burst;
              ram_wdata.prio    = in_item_i.prio;
            end
          end else if (n_act == '0) begin
            res_nxt          = '0;
            res_nxt.idle     = 1'b1;
            res_nxt.all_done = 1'b1;
            time_nxt         = time_inc;
            state_nxt        = ST_HOLD;
          end else begin
            ram_raddr = '0;
            chk_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = chk_r + SLOT_W'(1);
        if (better) begin
          found_nxt    = 1'b1;
          best_idx_nxt = chk_r;
          best_nxt     = ent;
        end
        if (chk_r == last_idx) begin
          state_nxt = ST_UPD;
        end else begin
          chk_nxt = chk_r + SLOT_W'(1);
        end
      end
      ST_UPD: begin
        res_nxt = '0;
        if (!found_r) begin
          res_nxt.idle = 1'b1;
        end else begin
          res_nxt.running_slot = 4'(best_idx_r);
          ram_we               = 1'b1;
          ram_wdata.remain     = best_r.remain - TIME_W'(1);
          if (best_r.remain == TIME_W'(1)) begin
            res_nxt.finished        = 1'b1;
            res_nxt.finish_time     = time_inc;
            res_nxt.turnaround_time = tat;
            res_nxt.waiting_time    = wt;
            if (done_r != DONE_MAX) begin
              done_nxt = done_r + DONE_W'(1);
            end
          end
        end
        res_nxt.all_done = (32'(done_nxt) >= 32'(n_act));
        time_nxt         = time_inc;
        state_nxt        = ST_HOLD;
      end
      ST_HOLD: begin
        if (res_ready_i) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      found_r <= 1'b0;
      time_r  <= '0;
      done_r  <= '0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
      time_r  <= time_nxt;
      done_r  <= done_nxt;
    end
    chk_r      <= chk_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    res_r      <= res_nxt;
  end

`ifndef SYNTHESIS
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r != ST_SCAN))
    else $error("table written during a scan");

  a_done_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (done_r >= $past(done_r)))
    else $error("completion count went down");

  a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (time_r >= $past(time_r)))
    else $error("time counter went down");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_o && res_r.idle) |-> (!res_r.finished && (res_r.running_slot == '0)))
    else $error("idle result carries a slot or a completion");

  a_time_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> $stable(time_r))
    else $error("time advanced during a scan");
`endif

endmodule

[sv/preemptive_priority_scheduler.sv]
// ----------------------------------------------------------------------------
// A load item is written into the table as it is accepted, and the input
// stays ready. A tick item scans the active slots (the process count,
// capped at 16) one slot per cycle through the RAM read port, then updates
// the chosen slot and passes its result on; no new item is taken until that
// result leaves the engine. A zero count skips the scan with an idle result.
// A result waiting in the output register holds the engine and the input.
// Reset (rst_n, synchronous) clears time, completion count and sets the
// process count to 16; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Top level: stream ports, configuration register and output register.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler
  import pps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] slot, [19:4] arrival, [35:20] burst, [51:36] prio
  input  logic [55:0] in_tdata,
  // [0] func
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] running_slot, [19:4] finish_time, [35:20] turnaround_time,
  // [51:36] waiting_time, [52] all_done
  output logic [55:0] out_tdata,
  // [0] idle, [1] finished
  output logic [1:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [PC_W-1:0] pc_r;
  logic            out_valid_r;
  res_t            out_res_r;
  item_t           item;
  logic            res_valid;
  logic            res_ready;
  res_t            res;
  reg_idx_t        reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_prdata = (reg_idx == REG_PROCESS_COUNT) ? 32'(pc_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_W'(PC_RESET);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (reg_idx == REG_PROCESS_COUNT)) begin
      pc_r <= cfg_pwdata[PC_W-1:0];
    end
  end

  assign item.func    = func_t'(in_tuser[0]);
  assign item.slot    = in_tdata[3:0];
  assign item.arrival = in_tdata[19:4];
  assign item.burst   = in_tdata[35:20];
  assign item.prio    = in_tdata[51:36];

  assign res_ready = !out_valid_r || out_tready;

  pps_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .process_count_i(pc_r),
    .in_valid_i     (in_tvalid),
    .in_ready_o     (in_tready),
    .in_item_i      (item),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.all_done, out_res_r.waiting_time,
                       out_res_r.turnaround_time, out_res_r.finish_time,
                       out_res_r.running_slot};
  assign out_tuser  = {out_res_r.finished, out_res_r.idle};

endmodule

[test/pps_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pps_checker
// Watches the item, result and register ports of the scheduler, keeps its own
// copy of the process table, time and completion count, works out the grant
// that each accepted tick item must produce, and compares every accepted
// result field by field against the oldest outstanding grant.
// ----------------------------------------------------------------------------
module pps_checker
  import pps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          failures,
  output int          pending
);

  logic [TIME_W-1:0] arrival_at  [SLOTS];
  logic [TIME_W-1:0] burst_len   [SLOTS];
  logic [TIME_W-1:0] work_left   [SLOTS];
  logic [TIME_W-1:0] priority_of [SLOTS];
  logic [TIME_W-1:0] sched_time;
  logic [DONE_W-1:0] done_cnt;
  logic [PC_W-1:0]   proc_count;
  res_t              expected_grants [$];
  int                mismatch_cnt;

  task automatic note_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      if (mismatch_cnt < 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_val,
                 act_val);
      end
      mismatch_cnt++;
    end
  endtask

  task automatic grant_tick(output res_t grant);
    int                n;
    int                i;
    int                best;
    bit                found;
    logic [TIME_W-1:0] t_end;
    logic [TIME_W-1:0] tat;
    n     = (proc_count > SLOTS) ? SLOTS : int'(proc_count);
    found = 1'b0;
    best  = 0;
    for (i = 0; i < n; i++) begin
      if (arrival_at[i] <= sched_time && work_left[i] != '0) begin
        if (!found || priority_of[i] < priority_of[best]) begin
          best  = i;
          found = 1'b1;
        end
      end
    end
    grant = '0;
    if (!found) begin
      grant.idle = 1'b1;
    end else begin
      grant.running_slot = best[3:0];
      work_left[best] = work_left[best] - 1'b1;
      if (work_left[best] == '0) begin
        t_end = (sched_time == TIME_MAX) ? TIME_MAX : sched_time + 1'b1;
        tat   = (t_end >= arrival_at[best]) ? t_end - arrival_at[best] : '0;
        grant.finished        = 1'b1;
        grant.finish_time     = t_end;
        grant.turnaround_time = tat;
        grant.waiting_time    = (tat >= burst_len[best]) ? tat - burst_len[best] : '0;
        if (done_cnt != DONE_MAX) begin
          done_cnt = done_cnt + 1'b1;
        end
      end
    end
    if (sched_time != TIME_MAX) begin
      sched_time = sched_time + 1'b1;
    end
    grant.all_done = (int'(done_cnt) >= n);
  endtask

  always @(posedge clk) begin
    res_t  grant;
    res_t  seen;
    logic [3:0] s;
    if (!rst_n) begin
      sched_time   = '0;
      done_cnt     = '0;
      proc_count   = PC_W'(PC_RESET);
      mismatch_cnt = 0;
      expected_grants.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        if (func_t'(in_tuser[0]) == FUNC_TICK) begin
          grant_tick(grant);
          expected_grants.push_back(grant);
        end else begin
          s = in_tdata[3:0];
          arrival_at[s]  = in_tdata[19:4];
          burst_len[s]   = in_tdata[35:20];
          work_left[s]   = in_tdata[35:20];
          priority_of[s] = in_tdata[51:36];
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          reg_idx_t'(cfg_paddr[2]) == REG_PROCESS_COUNT) begin
        proc_count = cfg_pwdata[PC_W-1:0];
      end
      if (out_tvalid && out_tready) begin
        seen.running_slot    = out_tdata[3:0];
        seen.finish_time     = out_tdata[19:4];
        seen.turnaround_time = out_tdata[35:20];
        seen.waiting_time    = out_tdata[51:36];
        seen.all_done        = out_tdata[52];
        seen.idle            = out_tuser[0];
        seen.finished        = out_tuser[1];
        if (expected_grants.size() == 0) begin
          if (mismatch_cnt < 10) begin
            $display("%0t: result item arrived with no tick outstanding", $realtime);
          end
          mismatch_cnt++;
        end else begin
          grant = expected_grants.pop_front();
          note_field("running_slot", grant.running_slot, seen.running_slot);
          note_field("idle", grant.idle, seen.idle);
          note_field("finished", grant.finished, seen.finished);
          note_field("finish_time", grant.finish_time, seen.finish_time);
          note_field("turnaround_time", grant.turnaround_time, seen.turnaround_time);
          note_field("waiting_time", grant.waiting_time, seen.waiting_time);
          note_field("all_done", grant.all_done, seen.all_done);
        end
      end
    end
    failures <= mismatch_cnt;
    pending  <= expected_grants.size();
  end

endmodule

[test/preemptive_priority_scheduler_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_test
// Drives load and tick items into the scheduler under several process counts,
// with random gaps on the input and random stalls on the result side, and
// ends with a short tick stretch on a single counted slot. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_test;
  import pps_pkg::*;

  localparam int               ITEM_TARGET = 1000;
  localparam int               CALM_AFTER  = 800;
  localparam int               SETTLE      = 25;
  localparam logic [2:0]       COUNT_ADDR  = {REG_PROCESS_COUNT, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          failures;
  int          pending;
  logic        calm = 1'b0;
  int          gap_rate = 0;
  int          stall_rate = 0;
  int          stall_left = 0;
  int          sent = 0;
  int          ticks_sent = 0;
  int          active = SLOTS;

  preemptive_priority_scheduler DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  pps_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .failures(failures), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (calm || stall_rate == 0) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 15) < stall_rate) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_item(input item_t it);
    if (!calm && gap_rate != 0 && $urandom_range(0, 7) < gap_rate) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, it.prio, it.burst, it.arrival, it.slot};
    in_tuser  <= it.func;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic load_slot(input logic [3:0] s, input logic [15:0] arr,
                           input logic [15:0] bur, input logic [15:0] pri);
    item_t it;
    it.func    = FUNC_LOAD;
    it.slot    = s;
    it.arrival = arr;
    it.burst   = bur;
    it.prio    = pri;
    push_item(it);
  endtask

  task automatic tick();
    item_t it;
    it         = '0;
    it.func    = FUNC_TICK;
    it.slot    = 4'($urandom);
    it.arrival = 16'($urandom);
    it.burst   = 16'($urandom);
    it.prio    = 16'($urandom);
    push_item(it);
    ticks_sent++;
  endtask

  // Loads mostly target counted slots with arrivals close to the current
  // time and small bursts, half with clustered priorities so that ties and
  // preemption happen often; a few get a random slot, arrival and burst.
  task automatic random_load();
    int          pick;
    int          near;
    logic [3:0]  s;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] p;
    pick = $urandom_range(0, 19);
    near = ticks_sent + $urandom_range(0, 12);
    s = (active == 0 || pick == 1) ? 4'($urandom_range(0, 15))
                                   : 4'($urandom_range(0, active - 1));
    a = (near > 65535) ? 16'hFFFF : near[15:0];
    b = 16'($urandom_range(1, 6));
    p = (pick < 10) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    if (pick == 0) begin
      s = 4'($urandom);
      a = 16'($urandom);
      b = 16'($urandom);
    end else if (pick == 2) begin
      a = 16'($urandom);
    end else if (pick == 3) begin
      a = 16'($urandom_range(0, ticks_sent));
    end else if (pick == 4) begin
      b = '0;
    end else if (pick == 5) begin
      b = 16'($urandom_range(7, 300));
    end
    load_slot(s, a, b, p);
  endtask

  task automatic write_count(input logic [4:0] v);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= COUNT_ADDR;
    cfg_pwdata  <= {27'b0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    active = (v > SLOTS) ? SLOTS : int'(v);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int         s;
    int         phase;
    logic [4:0] count;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every slot is loaded before the first tick since a tick scans them all.
    for (s = 0; s < SLOTS; s++) begin
      case (s)
        0:       load_slot(4'(s), 16'd0, 16'd3, 16'hFFFF);
        1:       load_slot(4'(s), 16'd0, 16'd2, 16'd0);
        2:       load_slot(4'(s), 16'hFFFF, 16'hFFFF, 16'd0);
        3:       load_slot(4'(s), 16'd0, 16'd0, 16'd0);
        4, 5:    load_slot(4'(s), 16'd1, 16'd1, 16'd9);
        default: load_slot(4'(s), 16'(s), 16'd1, 16'(1000 + s));
      endcase
    end
    repeat (8) tick();

    phase = 0;
    while (sent < ITEM_TARGET) begin
      drain();
      case (phase)
        0:       count = 5'd1;
        1:       count = 5'd16;
        2:       count = 5'd0;
        3:       count = 5'd31;
        4:       count = 5'd17;
        5:       count = 5'd2;
        default: count = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                                      : 5'($urandom_range(1, 16));
      endcase
      write_count(count);
      if (sent >= CALM_AFTER) begin
        calm <= 1'b1;
      end
      gap_rate = $urandom_range(0, 3);
      stall_rate <= $urandom_range(0, 3);
      repeat ($urandom_range(1, 8)) random_load();
      repeat ($urandom_range(4, 30)) begin
        if ($urandom_range(0, 7) == 0) begin
          random_load();
        end
        tick();
      end
      phase++;
    end

    // One counted slot whose arrival lies far ahead keeps the ticks short and
    // idle; a reload then runs it to completion.
    drain();
    calm <= 1'b1;
    write_count(5'd1);
    load_slot(4'd0, 16'd65530, 16'd10, 16'd3);
    repeat (20) tick();
    load_slot(4'd0, 16'd0, 16'd2, 16'hFFFF);
    repeat (3) tick();
    drain();

    if (failures == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[files.f]
sv/pps_pkg.sv
sv/pps_ram.sv
sv/pps_core.sv
sv/preemptive_priority_scheduler.sv
test/pps_checker.sv
test/preemptive_priority_scheduler_test.sv
